[hdl/lbc_pkg.sv]
// Shared types, constants and a helper function for the card number Luhn classifier.
// No dependencies.
package lbc_pkg;

    localparam int IN_W          = 54;
    localparam int NUM_DIGITS    = 17;
    localparam int BITS_PER_STEP = 3;
    localparam int CONV_STEPS    = IN_W / BITS_PER_STEP;
    localparam int IDX_W         = 5;

    localparam logic [1:0] VERDICT_INVALID = 2'd0;
    localparam logic [1:0] VERDICT_BRAND1  = 2'd1;
    localparam logic [1:0] VERDICT_BRAND2  = 2'd2;
    localparam logic [1:0] VERDICT_BRAND3  = 2'd3;

    localparam logic [4:0] LEN_13 = 5'd13;
    localparam logic [4:0] LEN_15 = 5'd15;
    localparam logic [4:0] LEN_16 = 5'd16;
    localparam logic [4:0] LEN_17 = 5'd17;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CONV  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    typedef struct packed {
        logic clear;
        logic conv;
        logic drain;
    } t_cell_ctl;

    // doubled digit folded back to one digit
    function automatic logic [3:0] luhn_double(input logic [3:0] d);
        logic [3:0] r;
        unique case (d)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

[hdl/lbc_cell.sv]
// One decimal digit cell: three shift-add-3 steps per cycle during conversion,
// shifts its digit down the chain during drain. Depends on lbc_pkg.
module lbc_cell import lbc_pkg::*; (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic [BITS_PER_STEP-1:0] i_carry,
    output logic [BITS_PER_STEP-1:0] o_carry,
    input  logic [3:0]               i_up,
    output logic [3:0]               o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] v [0:BITS_PER_STEP];
    logic [3:0] a [0:BITS_PER_STEP-1];

    always_comb begin
        v[0] = r_digit;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            a[k]       = (v[k] >= 4'd5) ? (v[k] + 4'd3) : v[k];
            o_carry[k] = a[k][3];
            v[k+1]     = {a[k][2:0], i_carry[k]};
        end
    end

    always_comb begin
        priority if (i_ctl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctl.conv) begin
            n_digit = v[BITS_PER_STEP];
        end else if (i_ctl.drain) begin
            n_digit = i_up;
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule

[hdl/card_number_luhn_classifier_top.sv]
// Card number Luhn classifier: 17-cell double-dabble chain, then drain with Luhn accumulation.
// Sequence: conversion in the chain, drain of the digits, then a done state that registers the o_valid strobe.
// A new transaction is accepted only while idle; busy stays high through conversion, drain and done.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset: synchronous active-low i_rst_n returns control to idle and clears the strobe.
// Depends on lbc_pkg and lbc_cell.
module card_number_luhn_classifier_top import lbc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [IN_W-1:0] i_card_number,
    output logic            busy,
    output logic            o_valid,
    output logic [1:0]      o_verdict,
    output logic [4:0]      o_digit_count,
    output logic            o_checksum_ok
);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx;
    logic [IN_W-1:0]    r_bin;
    logic [3:0]         r_sum;
    logic [4:0]         r_count;
    logic [3:0]         r_lead1;
    logic [3:0]         r_lead_low;
    logic [3:0]         r_prev;
    t_cell_ctl          w_ctl;
    logic               w_accept;

    logic [BITS_PER_STEP-1:0] w_carry [0:NUM_DIGITS];
    logic [3:0]               w_digit [0:NUM_DIGITS];

    logic [3:0] w_d;
    logic [3:0] w_dd;
    logic [4:0] w_sum_raw;
    logic [3:0] w_sum_next;
    logic       w_ok;
    logic [1:0] w_verdict;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    assign w_ctl.clear = w_accept;
    assign w_ctl.conv  = (r_state == ST_CONV);
    assign w_ctl.drain = (r_state == ST_DRAIN);

    // MSB of the remaining binary enters first
    assign w_carry[0] = {<<{r_bin[IN_W-1 -: BITS_PER_STEP]}};
    assign w_digit[NUM_DIGITS] = 4'd0;

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        lbc_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1]),
            .i_up    (w_digit[g+1]),
            .o_digit (w_digit[g])
        );
    end

    assign w_d        = w_digit[0];
    assign w_dd       = r_idx[0] ? luhn_double(w_d) : w_d;
    assign w_sum_raw  = {1'b0, r_sum} + {1'b0, w_dd};
    assign w_sum_next = (w_sum_raw >= 5'd10) ? 4'(w_sum_raw - 5'd10) : w_sum_raw[3:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (r_idx == IDX_W'(CONV_STEPS - 1)) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (r_idx == IDX_W'(NUM_DIGITS - 1)) n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept || (w_ctl.conv && r_idx == IDX_W'(CONV_STEPS - 1))) begin
                r_idx <= '0;
            end else if (w_ctl.conv || w_ctl.drain) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bin      <= i_card_number;
            r_sum      <= 4'd0;
            r_count    <= 5'd1;
            r_lead1    <= 4'd0;
            r_lead_low <= 4'd0;
            r_prev     <= 4'd0;
        end else if (w_ctl.conv) begin
            r_bin <= r_bin << BITS_PER_STEP;
        end else if (w_ctl.drain) begin
            r_sum  <= w_sum_next;
            r_prev <= w_d;
            if (w_d != 4'd0) begin
                r_count    <= 5'(r_idx) + 5'd1;
                r_lead1    <= w_d;
                r_lead_low <= r_prev;
            end
        end
    end

    assign w_ok = (r_sum == 4'd0);

    always_comb begin
        w_verdict = VERDICT_INVALID;
        priority if (!w_ok) begin
            w_verdict = VERDICT_INVALID;
        end else if (r_count == LEN_15 && r_lead1 == 4'd3
                     && (r_lead_low == 4'd4 || r_lead_low == 4'd7)) begin
            w_verdict = VERDICT_BRAND1;
        end else if ((r_count == LEN_13 || r_count == LEN_16) && r_lead1 == 4'd4) begin
            w_verdict = VERDICT_BRAND2;
        end else if (r_count == LEN_16 && r_lead1 == 4'd5
                     && r_lead_low >= 4'd1 && r_lead_low <= 4'd5) begin
            w_verdict = VERDICT_BRAND3;
        end else begin
            w_verdict = VERDICT_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            o_verdict     <= w_verdict;
            o_digit_count <= r_count;
            o_checksum_ok <= w_ok;
        end
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_count >= 5'd1 && o_digit_count <= LEN_17))
        else $error("digit count out of range");

    a_brand_needs_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict != VERDICT_INVALID) |-> o_checksum_ok)
        else $error("brand given without a passing checksum");

endmodule
